### src/tent_filter_sample_warp_macros.svh
// Assertion macros for the tent filter sample warp checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef TENT_FILTER_SAMPLE_WARP_MACROS_SVH
`define TENT_FILTER_SAMPLE_WARP_MACROS_SVH

// same-cycle implication
`define TFSW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tfsw check failed");

// next-cycle implication
`define TFSW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tfsw check failed");

`endif

### src/tfsw_pkg.sv
// Shared constants, types and the tent warp's init, root and output functions.
// No dependencies.
`timescale 1ns / 1ps

package tfsw_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned RAD_W      = COORD_BITS + 1;
  localparam int unsigned W_W        = 2 * COORD_BITS + 2;
  localparam int unsigned REM_W      = COORD_BITS + 2;
  localparam int unsigned ROOT_W     = COORD_BITS + 1;
  localparam int unsigned SH_W       = COORD_BITS + 4;
  localparam int unsigned SQ_ITERS   = COORD_BITS + 1;
  localparam int unsigned SQ_STEPS   = 4;
  localparam int unsigned SQ_STAGES  = (SQ_ITERS + SQ_STEPS - 1) / SQ_STEPS;

  typedef struct packed {
    logic              upper;
    logic [W_W-1:0]    w;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } crd_t;

  typedef struct packed {
    crd_t x;
    crd_t y;
    logic last;
  } pipe_t;

  function automatic crd_t crd_init(logic [COORD_BITS-1:0] u);
    crd_t            c;
    logic [RAD_W-1:0] rad;
    logic [RAD_W-1:0] diff;
    diff = {1'b1, {COORD_BITS{1'b0}}} - {1'b0, u};
    if (u[COORD_BITS-1]) begin
      rad = {diff[COORD_BITS-1:0], 1'b0};
    end else begin
      rad = {u, 1'b0};
    end
    c.upper = u[COORD_BITS-1];
    c.w     = {1'b0, rad, {COORD_BITS{1'b0}}};
    c.rem   = '0;
    c.root  = '0;
    return c;
  endfunction

  // one restoring square root step: bring down two radicand bits
  function automatic crd_t sqrt_step(crd_t c);
    crd_t            n;
    logic [SH_W-1:0] rem_sh;
    logic [SH_W-1:0] trial;
    logic [SH_W-1:0] sub;
    logic            ge;
    rem_sh = {c.rem, c.w[W_W-1 -: 2]};
    trial  = {1'b0, c.root, 2'b01};
    sub    = rem_sh - trial;
    ge     = (rem_sh >= trial);
    n.upper = c.upper;
    n.w     = {c.w[W_W-3:0], 2'b00};
    n.rem   = ge ? sub[REM_W-1:0] : rem_sh[REM_W-1:0];
    n.root  = {c.root[ROOT_W-2:0], ge};
    return n;
  endfunction

  function automatic logic [COORD_BITS-1:0] warp_out(crd_t c);
    logic [ROOT_W-1:0] one_v;
    logic [ROOT_W-1:0] diff;
    one_v = {1'b1, {COORD_BITS{1'b0}}};
    diff  = c.upper ? (one_v - c.root) : (one_v + c.root);
    return diff[COORD_BITS:1];
  endfunction

endpackage

### src/tfsw_if.sv
// Stream interfaces for input samples and warped results.
// Depends on tfsw_pkg.
`timescale 1ns / 1ps

interface tfsw_in_if import tfsw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] x_in;
  logic [COORD_BITS-1:0] y_in;
  logic                  last_in;

  modport source (output valid, output x_in, output y_in, output last_in, input ready);
  modport sink   (input valid, input x_in, input y_in, input last_in, output ready);
endinterface

interface tfsw_out_if import tfsw_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_out;
  logic signed [COORD_BITS-1:0] y_out;
  logic                         last_out;

  modport source (output valid, output x_out, output y_out, output last_out, input ready);
  modport sink   (input valid, input x_out, input y_out, input last_out, output ready);
endinterface

### src/tfsw_prep.sv
// Input stage: registers a sample and forms the root radicands.
// Depends on tfsw_pkg and tfsw_in_if.
`timescale 1ns / 1ps

module tfsw_prep import tfsw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tfsw_in_if.sink    in_i,
  output logic       valid_o,
  input  logic       ready_i,
  output pipe_t      data_o
);

  logic  valid_q;
  pipe_t data_q;
  pipe_t data_d;

  assign in_i.ready = !valid_q || ready_i;

  always_comb begin
    data_d.x    = crd_init(in_i.x_in);
    data_d.y    = crd_init(in_i.y_in);
    data_d.last = in_i.last_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### src/tfsw_root_pipe.sv
// Pipelined square root: up to SQ_STEPS restoring steps per register stage.
// Depends on tfsw_pkg.
`timescale 1ns / 1ps

module tfsw_root_pipe import tfsw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  pipe_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output pipe_t data_o
);

  logic  valid_q [SQ_STAGES];
  pipe_t data_q  [SQ_STAGES];
  logic  rdy     [SQ_STAGES+1];

  assign rdy[SQ_STAGES] = ready_i;

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    logic  in_valid;
    pipe_t in_data;
    pipe_t data_d;

    if (s == 0) begin : g_first
      assign in_valid = valid_i;
      assign in_data  = data_i;
    end else begin : g_next
      assign in_valid = valid_q[s-1];
      assign in_data  = data_q[s-1];
    end

    assign rdy[s] = !valid_q[s] || rdy[s+1];

    always_comb begin
      data_d = in_data;
      for (int i = 0; i < SQ_STEPS; i++) begin
        if (s * SQ_STEPS + i < SQ_ITERS) begin
          data_d.x = sqrt_step(data_d.x);
          data_d.y = sqrt_step(data_d.y);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        valid_q[s] <= in_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (in_valid && rdy[s]) begin
        data_q[s] <= data_d;
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = valid_q[SQ_STAGES-1];
  assign data_o  = data_q[SQ_STAGES-1];

endmodule

### src/tfsw_finish.sv
// Output stage: forms 1 - root or root - 1 and drops to Q1.15.
// Depends on tfsw_pkg and tfsw_out_if.
`timescale 1ns / 1ps

module tfsw_finish import tfsw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  pipe_t      data_i,
  tfsw_out_if.source out_o
);

  logic                  valid_q;
  logic [COORD_BITS-1:0] x_q;
  logic [COORD_BITS-1:0] y_q;
  logic                  last_q;

  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      x_q    <= warp_out(data_i.x);
      y_q    <= warp_out(data_i.y);
      last_q <= data_i.last;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.x_out    = $signed(x_q);
  assign out_o.y_out    = $signed(y_q);
  assign out_o.last_out = last_q;

endmodule

### src/tent_filter_sample_warp.sv
// Top level of the tent filter sample warp.
// Depends on tfsw_pkg, tfsw_if, tfsw_prep, tfsw_root_pipe, tfsw_finish.
//
//   port   dir  payload                       handshake
//   in_i   in   x_in, y_in (Q0.16), last_in   valid/ready
//   out_o  out  x_out, y_out (Q1.15), last_out valid/ready
//
// One item per cycle sustained while out_o is ready; a sample is registered
// in prep, in each square root stage (up to four root steps) and in finish.
// Every stage has its own valid bit and accepts when empty or draining, so
// a stall fills bubbles first and drops nothing.
// Reset clears the valid bits only.
`timescale 1ns / 1ps

module tent_filter_sample_warp import tfsw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tfsw_in_if.sink    in_i,
  tfsw_out_if.source out_o
);

  logic  prep_valid;
  logic  prep_ready;
  pipe_t prep_data;
  logic  root_valid;
  logic  root_ready;
  pipe_t root_data;

  tfsw_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (prep_valid),
    .ready_i (prep_ready),
    .data_o  (prep_data)
  );

  tfsw_root_pipe u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .data_i  (prep_data),
    .valid_o (root_valid),
    .ready_i (root_ready),
    .data_o  (root_data)
  );

  tfsw_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (root_valid),
    .ready_o (root_ready),
    .data_i  (root_data),
    .out_o   (out_o)
  );

endmodule

### src/tfsw_checker.sv
// Port-level checks for the tent filter sample warp, bound to the top level.
// Depends on tfsw_pkg and tent_filter_sample_warp_macros.svh.
`timescale 1ns / 1ps
`include "tent_filter_sample_warp_macros.svh"

module tfsw_checker import tfsw_pkg::*; (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic signed [COORD_BITS-1:0] x_out_i,
  input logic signed [COORD_BITS-1:0] y_out_i,
  input logic                         last_out_i
);

  // a free-running sink never stalls the source
  `TFSW_ASSERT_NOW(a_no_stall_when_drained, out_ready_i, in_ready_i)
  `TFSW_ASSERT_NEXT(a_out_valid_holds, out_valid_i && !out_ready_i, out_valid_i)
  `TFSW_ASSERT_NEXT(a_out_data_holds, out_valid_i && !out_ready_i,
    $stable(x_out_i) && $stable(y_out_i) && $stable(last_out_i))

endmodule

bind tent_filter_sample_warp tfsw_checker u_tfsw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .x_out_i     (out_o.x_out),
  .y_out_i     (out_o.y_out),
  .last_out_i  (out_o.last_out)
);
